### rtl/rpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative position bucket package
// Shared widths, register indexes, part selection codes and the constant
// fixed-point log2 used to build elaboration-time tables.
// ----------------------------------------------------------------------------
package rpb_pkg;

  localparam int POS_W      = 16;  // width of the position ports
  localparam int MAG_W      = 17;  // magnitude of key - (query + shift)
  localparam int CFG_DATA_W = 16;
  localparam int REG_IDX_W  = 2;
  localparam int BUCKET_W   = 7;
  localparam int ME_W       = 7;   // the exact-range bound never exceeds 127
  localparam int QUO_W      = 7;   // quotient bits kept before the clamp

  localparam int DEF_POSITION_BITS     = 16;
  localparam int DEF_LOG_FRACTION_BITS = 16;

  // Register indexes of the configuration port
  localparam logic [REG_IDX_W-1:0] REG_BIDIR  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COUNT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT  = 2'd3;

  // How the in-range part of the bucket is chosen
  localparam logic [1:0] PART_ZERO  = 2'd0;
  localparam logic [1:0] PART_EXACT = 2'd1;
  localparam logic [1:0] PART_LAST  = 2'd2;
  localparam logic [1:0] PART_LOG   = 2'd3;

  // log2(x) with f fraction bits; evaluated at elaboration only.
  function automatic longint unsigned fixed_log2(input longint unsigned x,
                                                 input int unsigned f);
    longint unsigned p;
    longint unsigned m;
    longint unsigned r;
    p = 0;
    for (int b = 1; b < 63; b++) begin
      if ((x >> b) != 0) p = longint'(b);
    end
    if (p >= f) m = x >> (p - f);
    else        m = x << (f - p);
    r = p << f;
    for (int i = 1; i <= 24; i++) begin
      if (i <= f) begin
        m = (m * m) >> f;
        if (m >= (longint'(2) << f)) begin
          m = m >> 1;
          r = r | (longint'(1) << (f - i));
        end
      end
    end
    return r;
  endfunction

endpackage

### rtl/relative_position_bucket_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative position bucket
// Maps a query/key position pair to an attention bias bucket through a
// fully pipelined fixed-point logarithm and a pipelined restoring divider.
// ----------------------------------------------------------------------------
// The block accepts one query/key request per clock while in_ready is high
// and returns one bucket per request, in order. Most of the pipeline is
// the log2 of the distance, which spends one pipeline stage on each
// fraction bit (one squaring multiplier per stage), followed by a
// seven-stage restoring divider for the log ratio. The whole pipeline
// advances together and holds when the output is stalled, so no request
// is lost or repeated. The log2 of distance_limit is worked out by a small
// sequential unit after reset and after every write to distance_limit;
// in_ready is held low while it runs. The log2 of the exact-range bound
// comes from a constant table of 128 entries.
module relative_position_bucket_top
  import rpb_pkg::*;
#(
  parameter int POSITION_BITS     = DEF_POSITION_BITS,
  parameter int LOG_FRACTION_BITS = DEF_LOG_FRACTION_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [POS_W-1:0]      query_index,
  input  logic [POS_W-1:0]      key_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BUCKET_W-1:0]   bucket
);

  localparam int F   = LOG_FRACTION_BITS;
  localparam int PW  = $clog2(MAG_W);     // leading-one position
  localparam int LW  = PW + F;            // fixed-point log2 width
  localparam int PRW = LW + 8;            // numerator times bucket span
  localparam int NS  = F + 14;            // pipeline stages
  localparam int SQ0 = 3;                 // first squaring stage
  localparam int DND = F + 3;             // numerator / denominator stage
  localparam int MUL = F + 4;             // product stage
  localparam int SAT = F + 5;             // quotient overflow stage
  localparam int DV0 = F + 6;             // first divider step
  localparam int CW  = $clog2(F + 1);

  // Position mask; positions wider than the ports keep every port bit.
  localparam logic [POS_W-1:0] PMASK =
    (POSITION_BITS >= POS_W) ? {POS_W{1'b1}} : POS_W'((64'd1 << POSITION_BITS) - 64'd1);

  localparam logic [2:0] LG_IDLE   = 3'b001;
  localparam logic [2:0] LG_NORM   = 3'b010;
  localparam logic [2:0] LG_SQUARE = 3'b100;

  typedef struct packed {
    logic                base;
    logic [7:0]          n;
    logic [ME_W-1:0]     me;
    logic [1:0]          mode;
    logic [MAG_W-1:0]    mag;
    logic [PW-1:0]       p;
    logic [F:0]          m;
    logic [LW-1:0]       r;
    logic [LW-1:0]       num;
    logic [LW-1:0]       den;
    logic [PRW-1:0]      rem;
    logic [QUO_W-1:0]    quo;
    logic [BUCKET_W-1:0] bkt;
  } item_t;

  // Configuration registers
  logic                  bidirectional_mode;
  logic [7:0]            bucket_count;
  logic [CFG_DATA_W-1:0] distance_limit;
  logic [CFG_DATA_W-1:0] query_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      bidirectional_mode <= 1'b1;
      bucket_count       <= 8'd32;
      distance_limit     <= 16'd128;
      query_shift        <= 16'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BIDIR: bidirectional_mode <= cfg_data[0];
        REG_COUNT: bucket_count       <= cfg_data[7:0];
        REG_LIMIT: distance_limit     <= cfg_data;
        REG_SHIFT: query_shift        <= cfg_data;
        default: ;
      endcase
    end
  end

  // log2(max_exact) table, built at elaboration.
  logic [LW-1:0] log_me_tab [1 << ME_W];
  for (genvar g = 0; g < (1 << ME_W); g++) begin : g_log_tab
    localparam logic [LW-1:0] LV = LW'(fixed_log2(longint'(g), F));
    assign log_me_tab[g] = LV;
  end

  // Sequential log2 of distance_limit.
  logic [2:0]    lg_state;
  logic [CW-1:0] lg_cnt;
  logic [F:0]    lg_m;
  logic [LW-1:0] lg_r;
  logic [LW-1:0] log_limit;
  logic [PW-1:0] lg_p;
  logic [MAG_W+F-1:0] lg_wide;
  logic [2*F+1:0]     lg_sq;
  logic [F+1:0]       lg_t;
  logic [LW-1:0]      lg_bit;
  logic [LW-1:0]      lg_r_next;
  logic [F:0]         lg_m_next;

  always_comb begin
    lg_p = '0;
    for (int b = 0; b < CFG_DATA_W; b++) begin
      if (distance_limit[b]) lg_p = PW'(b);
    end
    lg_wide = {1'b0, distance_limit, {F{1'b0}}} >> lg_p;
    lg_sq   = {{(F+1){1'b0}}, lg_m} * {{(F+1){1'b0}}, lg_m};
    lg_t    = lg_sq[2*F+1:F];
    lg_bit  = {{(LW-1){1'b0}}, 1'b1} << (CW'(F) - lg_cnt);
    if (lg_t[F+1]) begin
      lg_m_next = lg_t[F+1:1];
      lg_r_next = lg_r | lg_bit;
    end else begin
      lg_m_next = lg_t[F:0];
      lg_r_next = lg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lg_state <= LG_NORM;
      lg_cnt   <= '0;
    end else if (cfg_write && cfg_index == REG_LIMIT) begin
      lg_state <= LG_NORM;
    end else begin
      unique case (lg_state)
        LG_NORM: begin
          lg_state <= LG_SQUARE;
          lg_cnt   <= CW'(1);
        end
        LG_SQUARE: begin
          lg_cnt <= lg_cnt + CW'(1);
          if (lg_cnt == CW'(F)) lg_state <= LG_IDLE;
        end
        default: lg_state <= LG_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (lg_state == LG_NORM) begin
      lg_m <= lg_wide[F:0];
      lg_r <= {lg_p, {F{1'b0}}};
    end else if (lg_state == LG_SQUARE) begin
      lg_m <= lg_m_next;
      lg_r <= lg_r_next;
      if (lg_cnt == CW'(F)) log_limit <= lg_r_next;
    end
  end

  // Request pipeline: all stages move together.
  item_t          st [NS];
  item_t          nx [NS];
  logic [NS-1:0]  vld;
  logic           adv;

  assign adv      = !vld[NS-1] || out_ready;
  assign in_ready = adv && (lg_state == LG_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_valid && in_ready};
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (adv) st[s] <= nx[s];
    end
  end

  // Entry: signed distance, halving and part selection.
  logic [MAG_W-1:0] sum_qs;
  logic [MAG_W:0]   rel;
  logic [MAG_W:0]   rel_neg;
  logic             rel_pos;

  always_comb begin
    nx[0]   = '0;
    sum_qs  = {1'b0, query_index & PMASK} + {1'b0, query_shift & PMASK};
    rel     = {2'b00, key_index & PMASK} - {1'b0, sum_qs};
    rel_neg = -rel;
    rel_pos = !rel[MAG_W] && (rel != '0);
    nx[0].n = bidirectional_mode ? {1'b0, bucket_count[7:1]} : bucket_count;
    nx[0].me = nx[0].n[7:1];
    if (bidirectional_mode) begin
      nx[0].base = rel_pos;
      nx[0].mag  = rel_pos ? rel[MAG_W-1:0] : rel_neg[MAG_W-1:0];
    end else begin
      nx[0].base = 1'b0;
      nx[0].mag  = rel[MAG_W] ? rel_neg[MAG_W-1:0] : '0;
    end
    if (nx[0].me == '0)                                      nx[0].mode = PART_ZERO;
    else if (nx[0].mag < MAG_W'(nx[0].me))                   nx[0].mode = PART_EXACT;
    else if (distance_limit <= CFG_DATA_W'(nx[0].me))        nx[0].mode = PART_LAST;
    else                                                     nx[0].mode = PART_LOG;
  end

  // Leading-one position of the magnitude.
  always_comb begin
    nx[1]   = st[0];
    nx[1].p = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (st[0].mag[b]) nx[1].p = PW'(b);
    end
  end

  // Normalise the mantissa to [1,2).
  logic [MAG_W+F-1:0] norm_wide;
  always_comb begin
    nx[2]     = st[1];
    norm_wide = {st[1].mag, {F{1'b0}}} >> st[1].p;
    nx[2].m   = norm_wide[F:0];
    nx[2].r   = {st[1].p, {F{1'b0}}};
  end

  // One fraction bit per stage by squaring.
  for (genvar i = 1; i <= F; i++) begin : g_square
    logic [2*F+1:0] sq;
    logic [F+1:0]   t;
    always_comb begin
      nx[SQ0+i-1] = st[SQ0+i-2];
      sq = {{(F+1){1'b0}}, st[SQ0+i-2].m} * {{(F+1){1'b0}}, st[SQ0+i-2].m};
      t  = sq[2*F+1:F];
      if (t[F+1]) begin
        nx[SQ0+i-1].m       = t[F+1:1];
        nx[SQ0+i-1].r[F-i]  = 1'b1;
      end else begin
        nx[SQ0+i-1].m       = t[F:0];
      end
    end
  end

  // Log differences.
  logic [LW-1:0] lme;
  always_comb begin
    nx[DND]     = st[DND-1];
    lme         = log_me_tab[st[DND-1].me];
    nx[DND].den = log_limit - lme;
    nx[DND].num = (st[DND-1].r > lme) ? st[DND-1].r - lme : '0;
    if (st[DND-1].mode == PART_LOG && nx[DND].den == '0) nx[DND].mode = PART_LAST;
  end

  // Numerator times the logarithmic bucket span.
  always_comb begin
    nx[MUL]     = st[DND];
    nx[MUL].rem = PRW'({8'd0, st[DND].num} * {{LW{1'b0}}, st[DND].n - {1'b0, st[DND].me}});
  end

  // Quotient overflow: anything at or above the top quotient bit clamps later.
  always_comb begin
    nx[SAT] = st[MUL];
    if (st[MUL].rem >= {1'b0, st[MUL].den, {QUO_W{1'b0}}}) begin
      nx[SAT].quo = '1;
      nx[SAT].rem = '0;
    end else begin
      nx[SAT].quo = '0;
    end
  end

  // Restoring division, one quotient bit per stage, top bit first.
  for (genvar j = 0; j < QUO_W; j++) begin : g_divide
    localparam int BIT = QUO_W - 1 - j;
    logic [PRW-1:0] dsh;
    always_comb begin
      nx[DV0+j] = st[DV0+j-1];
      dsh       = PRW'({st[DV0+j-1].den, {BIT{1'b0}}});
      if (st[DV0+j-1].rem >= dsh) begin
        nx[DV0+j].rem      = st[DV0+j-1].rem - dsh;
        nx[DV0+j].quo[BIT] = 1'b1;
      end
    end
  end

  // Final bucket with clamps.
  logic [7:0] part;
  logic [7:0] top;
  logic [7:0] lsum;
  logic [8:0] total;
  always_comb begin
    nx[NS-1] = st[NS-2];
    top      = st[NS-2].n - 8'd1;
    lsum     = {1'b0, st[NS-2].me} + {1'b0, st[NS-2].quo};
    case (st[NS-2].mode)
      PART_ZERO:  part = '0;
      PART_EXACT: part = st[NS-2].mag[7:0];
      PART_LAST:  part = top;
      default:    part = (lsum > top) ? top : lsum;
    endcase
    total = (st[NS-2].base ? {1'b0, st[NS-2].n} : 9'd0) + {1'b0, part};
    nx[NS-1].bkt = (total > 9'd127) ? {BUCKET_W{1'b1}} : total[BUCKET_W-1:0];
  end

  assign out_valid = vld[NS-1];
  assign bucket    = st[NS-1].bkt;

  // No request may enter while the limit logarithm is being recomputed.
  a_hold_while_busy : assert property (@(posedge clk) disable iff (rst)
    lg_state != LG_IDLE |-> !in_ready)
    else $error("request accepted during limit log2 update");

  a_limit_restarts : assert property (@(posedge clk) disable iff (rst)
    cfg_write && cfg_index == REG_LIMIT |=> lg_state == LG_NORM)
    else $error("limit write did not restart log2 unit");

  a_bucket_range : assert property (@(posedge clk) disable iff (rst)
    out_valid && bucket_count != 8'd0 |-> {1'b0, bucket} < bucket_count)
    else $error("bucket outside configured range");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during stall");

endmodule

### verif/relative_position_bucket_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative position bucket testbench
// Drives query/key requests through the bucket block under random idling on
// both handshakes, predicts every bucket with an independent fixed-point
// model and compares results in order, across several register settings.
// ----------------------------------------------------------------------------
module relative_position_bucket_top_test
  import rpb_pkg::*;
();

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 14;
  localparam int SETTLE = LATENCY + FRAC + 20;

  // One row of the directed table. A known bucket is only typed in where it
  // can be read off at a glance; otherwise the predictor supplies it.
  typedef struct packed {
    logic [15:0] query;
    logic [15:0] key;
    logic        known;
    logic [6:0]  bucket;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [POS_W-1:0]      query_index;
  logic [POS_W-1:0]      key_index;
  logic                  out_valid;
  logic                  out_ready;
  logic [BUCKET_W-1:0]   bucket;

  // The predictor's own copy of the registers.
  logic        mode_bidir;
  logic [7:0]  pred_count;
  logic [15:0] pred_limit;
  logic [15:0] shift_q;

  logic [6:0] pending_buckets[$];
  int         fail_count;
  bit         sink_hold;      // long receiver hold-off requested
  int         hold_cycles;
  int         sink_draw;

  relative_position_bucket_top u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .query_index(query_index),
    .key_index  (key_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .bucket     (bucket)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // log2 in Q.16: leading-one position, then one squaring per fraction bit.
  function automatic longint unsigned log2_q16(input longint unsigned x);
    longint unsigned lead;
    longint unsigned mant;
    longint unsigned res;
    lead = 0;
    while (lead < 63 && (x >> (lead + 1)) != 0) lead++;
    mant = (lead >= FRAC) ? (x >> (lead - FRAC)) : (x << (FRAC - lead));
    res = lead << FRAC;
    for (int i = 1; i <= FRAC; i++) begin
      mant = (mant * mant) >> FRAC;
      if (mant >= (longint'(2) << FRAC)) begin
        mant = mant >> 1;
        res = res | (longint'(1) << (FRAC - i));
      end
    end
    return res;
  endfunction

  function automatic logic [6:0] bucket_of(input logic [15:0] q, input logic [15:0] k);
    longint distance;
    longint unsigned half, offset, magnitude, exact_max, part, total;
    longint unsigned log_me, span, log_d, rise;
    distance = longint'(k) - (longint'(q) + longint'(shift_q));
    half = pred_count;
    offset = 0;
    if (mode_bidir) begin
      half = half / 2;
      if (distance > 0) begin
        offset = half;
        magnitude = distance;
      end else begin
        magnitude = -distance;
      end
    end else begin
      magnitude = (distance < 0) ? -distance : 0;
    end
    exact_max = half / 2;
    if (exact_max == 0) part = 0;
    else if (magnitude < exact_max) part = magnitude;
    else if (pred_limit <= exact_max) part = half - 1;
    else begin
      log_me = log2_q16(exact_max);
      span = log2_q16(pred_limit) - log_me;
      log_d = log2_q16(magnitude);
      if (span == 0) part = half - 1;
      else begin
        rise = (log_d > log_me) ? log_d - log_me : 0;
        part = exact_max + (rise * (half - exact_max)) / span;
        if (part > half - 1) part = half - 1;
      end
    end
    total = offset + part;
    if (total > 127) total = 127;
    return total[6:0];
  endfunction

  // One register write; cfg_write is low again before anything else is driven.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BIDIR: mode_bidir = value[0];
      REG_COUNT: pred_count = value[7:0];
      REG_LIMIT: pred_limit = value;
      default:   shift_q = value;
    endcase
  endtask

  // Wait until every expected bucket has come back, then let the pipeline
  // settle before any register is touched.
  task automatic drain();
    while (pending_buckets.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Offer one request after a random gap; the expectation is queued at the
  // accepting edge so that it always precedes its result. Valid is left
  // high so that the next request can follow without a gap; the caller
  // drops it after the last one.
  task automatic send_request(input logic [15:0] q, input logic [15:0] k,
                              input bit known, input logic [6:0] known_bucket,
                              input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    query_index <= q;
    key_index   <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (known && known_bucket != bucket_of(q, k)) begin
      $error("table bucket: expected %0d, predictor %0d", known_bucket, bucket_of(q, k));
      fail_count++;
    end
    pending_buckets.push_back(known ? known_bucket : bucket_of(q, k));
  endtask

  // Random requests: mostly near the diagonal so that the exact, log and
  // clamped regions are all reached, with some fully random positions.
  task automatic random_batch(input int count);
    logic [15:0] q, k;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      q = 16'($urandom_range(0, 65535));
      if (sel < 4) k = q + 16'($urandom_range(0, 80)) - 16'd40;
      else if (sel < 7) k = q + 16'($urandom_range(0, 600)) - 16'd300;
      else if (sel < 8) k = q + 16'($urandom_range(0, 8000)) - 16'd4000;
      else k = 16'($urandom_range(0, 65535));
      send_request(q, k, 1'b0, 7'd0, ($urandom_range(0, 3) == 0));
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: random wait after each result, or a long hold-off when asked.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
    end else if (sink_hold) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= (hold_cycles == 1);
    end else if (out_valid && out_ready) begin
      sink_draw = $urandom_range(0, 6);
      hold_cycles <= sink_draw;
      out_ready <= (sink_draw == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_buckets.size() == 0) begin
        $error("bucket: unexpected result %0d", bucket);
        fail_count++;
      end else begin
        if (bucket !== pending_buckets[0]) begin
          $error("bucket: expected %0d, actual %0d", pending_buckets[0], bucket);
          fail_count++;
        end
        void'(pending_buckets.pop_front());
      end
    end
  end

  initial begin
    dir_row_t directed[$];
    int wait_cycles;
    fail_count  = 0;
    sink_hold   = 1'b0;
    rst         = 1'b1;
    cfg_write   = 1'b0;
    cfg_index   = REG_BIDIR;
    cfg_data    = '0;
    in_valid    = 1'b0;
    query_index = '0;
    key_index   = '0;
    mode_bidir  = 1'b1;
    pred_count  = 8'd32;
    pred_limit  = 16'd128;
    shift_q     = 16'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at the reset setting: 16 buckets a side, exact below 8.
    directed = '{
      '{16'd0,     16'd0,     1'b1, 7'd0},
      '{16'd0,     16'd1,     1'b1, 7'd17},
      '{16'd1,     16'd0,     1'b1, 7'd1},
      '{16'd0,     16'd7,     1'b1, 7'd23},
      '{16'd7,     16'd0,     1'b1, 7'd7},
      '{16'd0,     16'd8,     1'b0, 7'd0},
      '{16'd0,     16'd100,   1'b0, 7'd0},
      '{16'd0,     16'd128,   1'b1, 7'd31},
      '{16'd65535, 16'd0,     1'b1, 7'd15},
      '{16'd0,     16'd65535, 1'b1, 7'd31},
      '{16'd65535, 16'd65535, 1'b1, 7'd0},
      '{16'd300,   16'd12,    1'b0, 7'd0},
      '{16'hAAAA,  16'h5555,  1'b0, 7'd0},
      '{16'h5555,  16'hAAAA,  1'b0, 7'd0}
    };
    foreach (directed[i])
      send_request(directed[i].query, directed[i].key, directed[i].known,
                   directed[i].bucket, 1'b0);
    in_valid <= 1'b0;
    drain();

    // Unidirectional, a count of 128, largest limit, largest shift.
    write_reg(REG_BIDIR, 16'd0);
    write_reg(REG_COUNT, 16'd128);
    write_reg(REG_LIMIT, 16'd65535);
    write_reg(REG_SHIFT, 16'd65535);
    send_request(16'd0, 16'd0, 1'b1, 7'd127, 1'b0);
    send_request(16'd0, 16'd65535, 1'b1, 7'd0, 1'b0);
    random_batch(250);
    drain();

    // Too few buckets: only the bidirectional offset can remain.
    write_reg(REG_BIDIR, 16'd1);
    write_reg(REG_COUNT, 16'd2);
    write_reg(REG_SHIFT, 16'd0);
    send_request(16'd0, 16'd5, 1'b1, 7'd1, 1'b0);
    send_request(16'd5, 16'd0, 1'b1, 7'd0, 1'b0);
    random_batch(100);
    drain();

    // Limit not above the exact range, a limit of 1.
    write_reg(REG_COUNT, 16'd64);
    write_reg(REG_LIMIT, 16'd1);
    send_request(16'd100, 16'd0, 1'b1, 7'd31, 1'b0);
    random_batch(200);
    drain();

    // Counts above 128 push the bucket past 127, where it saturates.
    write_reg(REG_BIDIR, 16'd0);
    write_reg(REG_COUNT, 16'd255);
    write_reg(REG_LIMIT, 16'd200);
    random_batch(200);
    drain();

    // Back to reset-like values with a small shift; long receiver hold-off
    // so that the pipeline fills and stalls its input.
    write_reg(REG_BIDIR, 16'd1);
    write_reg(REG_COUNT, 16'd32);
    write_reg(REG_LIMIT, 16'd128);
    write_reg(REG_SHIFT, 16'd3);
    sink_hold = 1'b1;
    fork
      random_batch(150);
      begin
        wait_cycles = 0;
        while (wait_cycles < 200) begin
          @(posedge clk);
          wait_cycles++;
        end
        sink_hold = 1'b0;
      end
    join
    drain();

    // Random settings for the bulk of the run.
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_BIDIR, 16'($urandom_range(0, 1)));
      write_reg(REG_COUNT, 16'($urandom_range(2, 128)));
      write_reg(REG_LIMIT, 16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                             : $urandom_range(1, 400)));
      write_reg(REG_SHIFT, ($urandom_range(0, 1) == 0) ? 16'd0
                                                       : 16'($urandom_range(0, 65535)));
      random_batch(120);
      drain();
    end

    $display("");
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
